FILE: design/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg: shared types, codes and helpers of the source byte tokenizer
// Payload structs, token kind codes, scanner modes and character class
// functions used by the scanner, the token queue and the output stage.
// ----------------------------------------------------------------------------
package sbt_pkg;

   // largest source length; a byte at this offset or beyond is an error
   localparam int MAX_SOURCE  = 65536;
   localparam int POS_W       = $clog2(MAX_SOURCE + 1);
   // tokens one transfer can produce, and the count width for them
   localparam int MAX_RES     = 3;
   localparam int CNT_W       = $clog2(MAX_RES + 1);
   // token queue depth in bundles
   localparam int FIFO_DEPTH  = 4;
   localparam int PTR_W       = $clog2(FIFO_DEPTH);
   localparam int QCNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int WIN_W       = 48;

   // request commands
   localparam logic [1:0] CMD_BYTE = 2'd0;
   localparam logic [1:0] CMD_LAST = 2'd1;
   localparam logic [1:0] CMD_END  = 2'd2;

   // token kinds
   localparam logic [4:0] KIND_IDENT  = 5'd0;
   localparam logic [4:0] KIND_NUMBER = 5'd1;
   localparam logic [4:0] KIND_FN     = 5'd2;
   localparam logic [4:0] KIND_IF     = 5'd3;
   localparam logic [4:0] KIND_ELSE   = 5'd4;
   localparam logic [4:0] KIND_WHILE  = 5'd5;
   localparam logic [4:0] KIND_RETURN = 5'd6;
   localparam logic [4:0] KIND_PRINT  = 5'd7;
   localparam logic [4:0] KIND_LET    = 5'd8;
   localparam logic [4:0] KIND_LPAREN = 5'd9;
   localparam logic [4:0] KIND_RPAREN = 5'd10;
   localparam logic [4:0] KIND_LBRACE = 5'd11;
   localparam logic [4:0] KIND_RBRACE = 5'd12;
   localparam logic [4:0] KIND_COMMA  = 5'd13;
   localparam logic [4:0] KIND_SEMI   = 5'd14;
   localparam logic [4:0] KIND_PLUS   = 5'd15;
   localparam logic [4:0] KIND_MINUS  = 5'd16;
   localparam logic [4:0] KIND_STAR   = 5'd17;
   localparam logic [4:0] KIND_SLASH  = 5'd18;
   localparam logic [4:0] KIND_LT     = 5'd19;
   localparam logic [4:0] KIND_LE     = 5'd20;
   localparam logic [4:0] KIND_ASSIGN = 5'd21;
   localparam logic [4:0] KIND_EQ     = 5'd22;
   localparam logic [4:0] KIND_END    = 5'd23;
   localparam logic [4:0] KIND_ERROR  = 5'd24;

   // characters with a role of their own
   localparam logic [7:0] CH_SLASH = "/";
   localparam logic [7:0] CH_DOT   = ".";
   localparam logic [7:0] CH_LT    = "<";
   localparam logic [7:0] CH_EQ    = "=";
   localparam logic [7:0] CH_UNDER = "_";
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = " ";

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_INT,
      MODE_FRAC,
      MODE_LT,
      MODE_EQ,
      MODE_SLASH,
      MODE_COMMENT
   } scan_mode_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] source_byte;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] start_offset;
      logic [15:0] token_length;
      logic [15:0] line_number;
      logic [7:0]  bad_byte;
      logic        last_of_source;
   } rsp_type;

   // all tokens of one transfer, oldest in slot zero
   typedef struct packed {
      rsp_type [MAX_RES-1:0] tok;
      logic [CNT_W-1:0]      count;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } q_wr_type;

   typedef struct packed {
      logic    valid;
      rsp_type tok;
   } pend_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {["a":"z"], ["A":"Z"]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   // single-byte punctuation, error kind when the byte is none of them
   function automatic logic [4:0] punct_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         ",":     k = KIND_COMMA;
         ";":     k = KIND_SEMI;
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

   // fold an identifier to a keyword from its last six bytes and its length
   function automatic logic [4:0] kw_kind(input logic [WIN_W-1:0] w,
                                          input logic [POS_W-1:0] len);
      logic [4:0] k;
      k = KIND_IDENT;
      if (len == POS_W'(2) && w[15:0] == "fn")     k = KIND_FN;
      if (len == POS_W'(2) && w[15:0] == "if")     k = KIND_IF;
      if (len == POS_W'(4) && w[31:0] == "else")   k = KIND_ELSE;
      if (len == POS_W'(5) && w[39:0] == "while")  k = KIND_WHILE;
      if (len == POS_W'(6) && w[47:0] == "return") k = KIND_RETURN;
      if (len == POS_W'(5) && w[39:0] == "print")  k = KIND_PRINT;
      if (len == POS_W'(3) && w[23:0] == "let")    k = KIND_LET;
      return k;
   endfunction

   function automatic logic [15:0] sat16(input logic [POS_W-1:0] v);
      logic [15:0] r;
      if (v > POS_W'(65535)) r = 16'hffff;
      else                   r = 16'(v);
      return r;
   endfunction

   function automatic rsp_type make_tok(input logic [4:0] kind, input logic [15:0] start,
                                        input logic [15:0] len, input logic [15:0] line,
                                        input logic [7:0] bad, input logic last);
      rsp_type t;
      t.token_kind     = kind;
      t.start_offset   = start;
      t.token_length   = len;
      t.line_number    = line;
      t.bad_byte       = bad;
      t.last_of_source = last;
      return t;
   endfunction

endpackage

FILE: design/sbt_scan.sv
// ----------------------------------------------------------------------------
// sbt_scan: front end of the tokenizer
// Takes one source byte per transfer, runs the scanner state and writes
// every token the byte closes or forms into the token queue as one bundle.
// ----------------------------------------------------------------------------
module sbt_scan import sbt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_ready,
   input  req_type  req_data,
   output q_wr_type wr
);

   scan_mode_type    mode_ff, mode_in;
   logic [POS_W-1:0] tstart_ff, tstart_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      line_ff, line_in;
   logic [WIN_W-1:0] win_ff, win_in;
   logic             hold_ff, hold_in;

   logic             accept;
   logic [CNT_W-1:0] n;
   bundle_type       b;
   logic             used;
   logic             err;
   logic             do_flush;
   logic [7:0]       c;
   logic [4:0]       pk;
   pend_type         fr;

   // token pending at the current state, as the byte that ends it sees it
   function automatic pend_type flush_tok(input scan_mode_type m,
                                          input logic [POS_W-1:0] ts,
                                          input logic [POS_W-1:0] ps,
                                          input logic [15:0] ln,
                                          input logic [WIN_W-1:0] w);
      logic [POS_W-1:0] len;
      pend_type         r;
      len     = ps - ts;
      r.valid = 1'b1;
      r.tok   = '0;
      case (m)
         MODE_IDENT: r.tok = make_tok(kw_kind(w, len), sat16(ts), sat16(len), ln, 8'h00, 1'b0);
         MODE_INT,
         MODE_FRAC:  r.tok = make_tok(KIND_NUMBER, sat16(ts), sat16(len), ln, 8'h00, 1'b0);
         MODE_LT:    r.tok = make_tok(KIND_LT, sat16(ts), 16'd1, ln, 8'h00, 1'b0);
         MODE_EQ:    r.tok = make_tok(KIND_ASSIGN, sat16(ts), 16'd1, ln, 8'h00, 1'b0);
         MODE_SLASH: r.tok = make_tok(KIND_SLASH, sat16(ts), 16'd1, ln, 8'h00, 1'b0);
         default:    r.valid = 1'b0;
      endcase
      return r;
   endfunction

   assign accept = req_valid && req_ready;
   assign c      = req_data.source_byte;

   // scanner next state and token bundle
   always_comb begin
      mode_in   = mode_ff;
      tstart_in = tstart_ff;
      pos_in    = pos_ff;
      line_in   = line_ff;
      win_in    = win_ff;
      hold_in   = hold_ff;
      n         = '0;
      b         = '0;
      used      = 1'b0;
      err       = 1'b0;
      do_flush  = 1'b0;
      pk        = KIND_ERROR;
      fr        = '0;

      if ((req_data.command == CMD_BYTE || req_data.command == CMD_LAST) && !hold_ff) begin
         if (pos_ff >= POS_W'(MAX_SOURCE)) begin
            err = 1'b1;
         end else begin
            // does the byte extend the pending token
            case (mode_ff)
               MODE_IDENT: begin
                  if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                     win_in = {win_ff[WIN_W-9:0], c};
                     used   = 1'b1;
                  end else begin
                     do_flush = 1'b1;
                  end
               end
               MODE_INT: begin
                  if (is_digit(c)) begin
                     used = 1'b1;
                  end else if (c == CH_DOT) begin
                     mode_in = MODE_FRAC;
                     used    = 1'b1;
                  end else begin
                     do_flush = 1'b1;
                  end
               end
               MODE_FRAC: begin
                  if (is_digit(c)) used = 1'b1;
                  else             do_flush = 1'b1;
               end
               MODE_LT, MODE_EQ: begin
                  if (c == CH_EQ) begin
                     b.tok[n] = make_tok((mode_ff == MODE_LT) ? KIND_LE : KIND_EQ,
                                         sat16(tstart_ff), 16'd2, line_ff, 8'h00, 1'b0);
                     n        = n + 1'b1;
                     mode_in  = MODE_IDLE;
                     used     = 1'b1;
                  end else begin
                     do_flush = 1'b1;
                  end
               end
               MODE_SLASH: begin
                  if (c == CH_SLASH) begin
                     mode_in = MODE_COMMENT;
                     used    = 1'b1;
                  end else begin
                     do_flush = 1'b1;
                  end
               end
               MODE_COMMENT: begin
                  if (c == CH_LF) mode_in = MODE_IDLE;
                  else            used = 1'b1;
               end
               default: mode_in = MODE_IDLE;
            endcase

            // close the pending token
            if (do_flush) begin
               fr = flush_tok(mode_ff, tstart_ff, pos_ff, line_ff, win_ff);
               if (fr.valid) begin
                  b.tok[n] = fr.tok;
                  n        = n + 1'b1;
               end
               mode_in = MODE_IDLE;
            end

            // scan the byte afresh
            if (!used) begin
               if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
                  mode_in = MODE_IDLE;
               end else if (c == CH_LF) begin
                  if (line_in != 16'hffff) line_in = line_in + 16'd1;
               end else if (is_alpha(c) || c == CH_UNDER) begin
                  mode_in   = MODE_IDENT;
                  tstart_in = pos_ff;
                  win_in    = {{(WIN_W-8){1'b0}}, c};
               end else if (is_digit(c)) begin
                  mode_in   = MODE_INT;
                  tstart_in = pos_ff;
               end else if (c == CH_SLASH) begin
                  mode_in   = MODE_SLASH;
                  tstart_in = pos_ff;
               end else if (c == CH_LT) begin
                  mode_in   = MODE_LT;
                  tstart_in = pos_ff;
               end else if (c == CH_EQ) begin
                  mode_in   = MODE_EQ;
                  tstart_in = pos_ff;
               end else begin
                  pk = punct_kind(c);
                  if (pk == KIND_ERROR) begin
                     err = 1'b1;
                  end else begin
                     b.tok[n] = make_tok(pk, sat16(pos_ff), 16'd1, line_in, 8'h00, 1'b0);
                     n        = n + 1'b1;
                  end
               end
            end
         end

         // error: flush what is pending, report the byte, ignore the rest
         if (err) begin
            fr = flush_tok(mode_in, tstart_in, pos_in, line_in, win_in);
            if (fr.valid) begin
               b.tok[n] = fr.tok;
               n        = n + 1'b1;
            end
            mode_in  = MODE_IDLE;
            b.tok[n] = make_tok(KIND_ERROR, sat16(pos_ff), 16'd1, line_in, c, 1'b1);
            n        = n + 1'b1;
            hold_in  = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end

      // end of source: pending token, end token, then back to reset state
      if (req_data.command != CMD_BYTE) begin
         if (!hold_in) begin
            fr = flush_tok(mode_in, tstart_in, pos_in, line_in, win_in);
            if (fr.valid) begin
               b.tok[n] = fr.tok;
               n        = n + 1'b1;
            end
            b.tok[n] = make_tok(KIND_END, sat16(pos_in), 16'd0, line_in, 8'h00, 1'b1);
            n        = n + 1'b1;
         end
         mode_in   = MODE_IDLE;
         tstart_in = '0;
         pos_in    = '0;
         line_in   = 16'd1;
         win_in    = '0;
         hold_in   = 1'b0;
      end

      b.count   = n;
      wr.valid  = accept && (n != '0);
      wr.bundle = b;
   end

   // scanner mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

   // position, line and identifier window
   always_ff @(posedge clock) begin
      if (reset) begin
         tstart_ff <= '0;
         pos_ff    <= '0;
         line_ff   <= 16'd1;
         win_ff    <= '0;
         hold_ff   <= 1'b0;
      end else if (accept) begin
         tstart_ff <= tstart_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         win_ff    <= win_in;
         hold_ff   <= hold_in;
      end
   end

`ifndef NO_ASSERTIONS
   // after an error, plain bytes produce nothing
   assert property (@(posedge clock) disable iff (reset)
      (accept && hold_ff && req_data.command == CMD_BYTE) |-> !wr.valid)
      else $error("sbt_scan: token produced while error hold is set");

   // the line count never drops to zero
   assert property (@(posedge clock) disable iff (reset) line_ff != 16'd0)
      else $error("sbt_scan: line count is zero");
`endif

endmodule

FILE: design/sbt_fifo.sv
// ----------------------------------------------------------------------------
// sbt_fifo: token bundle queue
// Decouples the scanner from the output stage; holds bundles of up to
// three tokens and shows the oldest one at its head.
// ----------------------------------------------------------------------------
module sbt_fifo import sbt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_wr_type   wr,
   input  logic       pop,
   output logic       full,
   output logic       head_valid,
   output bundle_type head
);

   bundle_type        mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign full       = (count_ff == QCNT_W'(FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr.valid && !do_pop)      count_in = count_ff + 1'b1;
      else if (!wr.valid && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // bundle storage
   always_ff @(posedge clock) begin
      if (wr.valid) begin
         mem_ff[wr_ptr_ff] <= wr.bundle;
      end
   end

`ifndef NO_ASSERTIONS
   // never written while full
   assert property (@(posedge clock) disable iff (reset) !(wr.valid && full))
      else $error("sbt_fifo: write while full");

   // occupancy stays within the depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= QCNT_W'(FIFO_DEPTH))
      else $error("sbt_fifo: occupancy beyond depth");
`endif

endmodule

FILE: design/sbt_drain.sv
// ----------------------------------------------------------------------------
// sbt_drain: back end of the tokenizer
// Walks the head bundle one token at a time into the output register and
// releases the bundle from the queue with its last token.
// ----------------------------------------------------------------------------
module sbt_drain import sbt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  bundle_type head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             slot_free;
   logic             take;
   logic             last_tok;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign take      = slot_free && head_valid;
   assign last_tok  = (idx_ff == head.count - 1'b1);
   assign pop       = take && last_tok;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // next token into the output register
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = head.tok[idx_ff];
         idx_in       = last_tok ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // the token index stays inside the head bundle
   assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff < head.count))
      else $error("sbt_drain: token index past bundle count");

   // an idle queue leaves the index at the first slot
   assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (idx_ff == '0))
      else $error("sbt_drain: stale token index with empty queue");
`endif

endmodule

FILE: design/source_byte_tokenizer.sv
// ----------------------------------------------------------------------------
// source_byte_tokenizer: streaming lexer from source bytes to token spans
// Top level: scanner front end, bundle queue and token output stage.
// ----------------------------------------------------------------------------
// The block takes one source byte per request transfer, one per cycle while
// the queue has room, and returns tokens as kind, start offset, length,
// line, bad byte and an end flag. A byte may close a pending token, form a
// token of its own and end the source, so one transfer yields zero to three
// tokens; these go into a four-entry queue as one bundle and the output
// register hands out one token per cycle while the receiver is ready, a
// token passing from the queue into the output register and from there to
// the result port. Request and result sides therefore stall on their own:
// input keeps a rate of one byte per cycle as long as tokens average no
// more than one per byte, and the single-token output register sets the peak
// rate at one token per cycle; several tokens from one byte wait in the queue.
module source_byte_tokenizer import sbt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   q_wr_type   wr;
   logic       full;
   logic       head_valid;
   bundle_type head;
   logic       pop;

   // take a byte whenever the queue has room for its bundle
   assign req_ready = !full;

   sbt_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .wr        (wr)
   );

   sbt_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head       (head)
   );

   sbt_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: tb/tb_source_byte_tokenizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_source_byte_tokenizer: self-checking bench for the source byte tokenizer
// Feeds short directed sources and then random token streams, and runs under
// several idle mixes on both channels. A long receiver hold fills the block.
// A scanner model in the bench predicts every token, and a checker compares
// each result transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_source_byte_tokenizer;
   import sbt_pkg::*;

   localparam logic [1:0] CMD_END_ALT = 2'd3;

   typedef enum int {CLOSE_LAST, CLOSE_END, CLOSE_ALT} close_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // scanner model state
   scan_mode_type sc_mode;
   int unsigned   tok_start;
   int unsigned   byte_pos;
   int unsigned   line_no;
   logic [47:0]   kw_window;
   bit            err_hold;

   rsp_type     awaited_tokens[$];
   logic [7:0]  src_bytes[$];
   int          fail_count;
   int unsigned live_items;
   int          tx_idle_pct;
   int          rx_idle_pct;
   bit          hold_request;
   int          hold_left;

   logic [7:0] punct_chars [9] = '{"(", ")", "{", "}", ",", ";", "+", "-", "*"};
   logic [7:0] blank_chars [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
   string      keywords [7] = '{"fn", "if", "else", "while", "return", "print", "let"};

   source_byte_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("source_byte_tokenizer test failed");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [15:0] clip16(input int unsigned v);
      return (v > 32'd65535) ? 16'hffff : 16'(v);
   endfunction

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_numeral(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void clear_scanner();
      sc_mode   = MODE_IDLE;
      tok_start = 0;
      byte_pos  = 0;
      line_no   = 1;
      kw_window = '0;
      err_hold  = 1'b0;
   endfunction

   function automatic void push_token(input logic [4:0] kind, input int unsigned start,
                                      input int unsigned len, input logic [7:0] bad,
                                      input logic last);
      rsp_type t;
      t.token_kind     = kind;
      t.start_offset   = clip16(start);
      t.token_length   = clip16(len);
      t.line_number    = clip16(line_no);
      t.bad_byte       = bad;
      t.last_of_source = last;
      awaited_tokens   = {awaited_tokens, t};
   endfunction

   // identifier to keyword, from its length and the trailing window bytes
   function automatic logic [4:0] fold_keyword(input int unsigned len);
      logic [4:0] k;
      k = KIND_IDENT;
      case (len)
         2: begin
            if (kw_window[15:0] == "fn") k = KIND_FN;
            if (kw_window[15:0] == "if") k = KIND_IF;
         end
         3: if (kw_window[23:0] == "let") k = KIND_LET;
         4: if (kw_window[31:0] == "else") k = KIND_ELSE;
         5: begin
            if (kw_window[39:0] == "while") k = KIND_WHILE;
            if (kw_window[39:0] == "print") k = KIND_PRINT;
         end
         6: if (kw_window[47:0] == "return") k = KIND_RETURN;
         default: k = KIND_IDENT;
      endcase
      return k;
   endfunction

   // close whatever token is open; a comment closes silently
   function automatic void flush_pending();
      int unsigned len;
      len = byte_pos - tok_start;
      case (sc_mode)
         MODE_IDENT:          push_token(fold_keyword(len), tok_start, len, 8'h00, 1'b0);
         MODE_INT, MODE_FRAC: push_token(KIND_NUMBER, tok_start, len, 8'h00, 1'b0);
         MODE_LT:             push_token(KIND_LT, tok_start, 1, 8'h00, 1'b0);
         MODE_EQ:             push_token(KIND_ASSIGN, tok_start, 1, 8'h00, 1'b0);
         MODE_SLASH:          push_token(KIND_SLASH, tok_start, 1, 8'h00, 1'b0);
         default: ;
      endcase
      sc_mode = MODE_IDLE;
   endfunction

   function automatic void mark_error(input logic [7:0] c, input int unsigned p);
      flush_pending();
      push_token(KIND_ERROR, p, 1, c, 1'b1);
      err_hold = 1'b1;
   endfunction

   function automatic void scan_source_byte(input logic [7:0] c);
      int unsigned p;
      bit          used;
      logic [4:0]  pk;
      p    = byte_pos;
      used = 1'b0;
      pk   = KIND_ERROR;
      if (err_hold) return;
      if (p >= MAX_SOURCE) begin
         mark_error(c, p);
         return;
      end
      // try to extend the open token
      case (sc_mode)
         MODE_IDENT: begin
            if (is_letter(c) || is_numeral(c) || c == CH_UNDER) begin
               kw_window = {kw_window[39:0], c};
               used = 1'b1;
            end else flush_pending();
         end
         MODE_INT: begin
            if (is_numeral(c)) used = 1'b1;
            else if (c == CH_DOT) begin
               sc_mode = MODE_FRAC;
               used = 1'b1;
            end else flush_pending();
         end
         MODE_FRAC: begin
            if (is_numeral(c)) used = 1'b1;
            else flush_pending();
         end
         MODE_LT, MODE_EQ: begin
            if (c == CH_EQ) begin
               push_token((sc_mode == MODE_LT) ? KIND_LE : KIND_EQ, tok_start, 2,
                          8'h00, 1'b0);
               sc_mode = MODE_IDLE;
               used = 1'b1;
            end else flush_pending();
         end
         MODE_SLASH: begin
            if (c == CH_SLASH) begin
               sc_mode = MODE_COMMENT;
               used = 1'b1;
            end else flush_pending();
         end
         MODE_COMMENT: begin
            if (c == CH_LF) sc_mode = MODE_IDLE;
            else used = 1'b1;
         end
         default: sc_mode = MODE_IDLE;
      endcase
      // scan the byte afresh
      if (!used) begin
         if (c == CH_LF) begin
            if (line_no < 65535) line_no++;
         end else if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
         end else if (is_letter(c) || c == CH_UNDER) begin
            sc_mode   = MODE_IDENT;
            tok_start = p;
            kw_window = {40'd0, c};
         end else if (is_numeral(c)) begin
            sc_mode   = MODE_INT;
            tok_start = p;
         end else if (c == CH_SLASH) begin
            sc_mode   = MODE_SLASH;
            tok_start = p;
         end else if (c == CH_LT) begin
            sc_mode   = MODE_LT;
            tok_start = p;
         end else if (c == CH_EQ) begin
            sc_mode   = MODE_EQ;
            tok_start = p;
         end else begin
            for (int i = 0; i < 9; i++)
               if (c == punct_chars[i]) pk = KIND_LPAREN + 5'(i);
            if (pk == KIND_ERROR) begin
               mark_error(c, p);
               return;
            end
            push_token(pk, p, 1, 8'h00, 1'b0);
         end
      end
      byte_pos = p + 1;
   endfunction

   function automatic void lex_item(input req_type item);
      if (item.command == CMD_BYTE || item.command == CMD_LAST)
         scan_source_byte(item.source_byte);
      if (item.command != CMD_BYTE) begin
         if (!err_hold) begin
            flush_pending();
            push_token(KIND_END, byte_pos, 0, 8'h00, 1'b1);
         end
         clear_scanner();
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // compare every result transfer with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_tokens.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected token, expected none, actual %h", $time, rsp_data);
         end else begin
            want = awaited_tokens.pop_front();
            check_field("token_kind", 16'(want.token_kind), 16'(rsp_data.token_kind));
            check_field("start_offset", want.start_offset, rsp_data.start_offset);
            check_field("token_length", want.token_length, rsp_data.token_length);
            check_field("line_number", want.line_number, rsp_data.line_number);
            check_field("bad_byte", 16'(want.bad_byte), 16'(rsp_data.bad_byte));
            check_field("last_of_source", 16'(want.last_of_source),
                        16'(rsp_data.last_of_source));
         end
      end
   end

   // receiver: random idling, or a long counted hold on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = 80;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
      req_type item;
      item.command     = cmd;
      item.source_byte = b;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (!err_hold) live_items++;
      lex_item(item);
   endtask

   // sender pauses until every predicted token has come out
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_tokens.size() != 0);
   endtask

   task automatic send_source(input close_type ending);
      int n;
      n = src_bytes.size();
      for (int i = 0; i < n; i++)
         send_item((ending == CLOSE_LAST && i == n - 1) ? CMD_LAST : CMD_BYTE, src_bytes[i]);
      if (ending == CLOSE_END || (ending == CLOSE_LAST && n == 0))
         send_item(CMD_END, 8'($urandom_range(255)));
      else if (ending == CLOSE_ALT)
         send_item(CMD_END_ALT, 8'($urandom_range(255)));
   endtask

   // append one byte to the source under construction
   function automatic void append_byte(input logic [7:0] c);
      src_bytes = {src_bytes, c};
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endfunction

   function automatic void set_text(input string s);
      src_bytes.delete();
      add_text(s);
   endfunction

   function automatic logic [7:0] ident_byte(input bit first);
      int unsigned r;
      r = $urandom_range(first ? 52 : 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return CH_UNDER;
      return 8'("0" + r - 53);
   endfunction

   function automatic logic [7:0] digit_byte();
      return 8'("0" + $urandom_range(9));
   endfunction

   // mostly well-formed tokens with random content, some noise bytes
   function automatic void make_source();
      int unsigned pick;
      int unsigned k;
      src_bytes.delete();
      repeat ($urandom_range(12, 1)) begin
         pick = $urandom_range(99);
         if (pick < 20) begin
            add_text(keywords[$urandom_range(6)]);
         end else if (pick < 42) begin
            append_byte(ident_byte(1'b1));
            repeat ($urandom_range(7)) append_byte(ident_byte(1'b0));
         end else if (pick < 58) begin
            repeat ($urandom_range(4, 1)) append_byte(digit_byte());
            if ($urandom_range(1)) begin
               append_byte(CH_DOT);
               repeat ($urandom_range(3)) append_byte(digit_byte());
            end
         end else if (pick < 85) begin
            k = $urandom_range(13);
            case (k)
               9:       add_text("/");
               10:      add_text("<");
               11:      add_text("=");
               12:      add_text("<=");
               13:      add_text("==");
               default: append_byte(punct_chars[k]);
            endcase
         end else if (pick < 95) begin
            // comment body may hold any byte but LF; the LF is optional
            add_text("//");
            repeat ($urandom_range(6)) begin
               k = $urandom_range(255);
               append_byte((k == 10) ? CH_DOT : 8'(k));
            end
            if ($urandom_range(1)) append_byte(CH_LF);
         end else begin
            append_byte(8'($urandom_range(255)));
         end
         if ($urandom_range(99) < 65) append_byte(blank_chars[$urandom_range(3)]);
      end
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      // trailing dot stays in the number
      set_text("1.");
      send_source(CLOSE_LAST);
      // pending ident, punctuation and End from one transfer
      set_text("ab;");
      send_source(CLOSE_LAST);
      // lone slash and lone '<' closed by the end of source
      set_text("/");
      send_source(CLOSE_END);
      set_text("<");
      send_source(CLOSE_ALT);
      set_text("==");
      send_source(CLOSE_LAST);
      // unexpected high byte, then bytes ignored and no End
      set_text("a");
      append_byte(8'hff);
      add_text("b");
      send_source(CLOSE_END);
      // zero byte errors at once; final byte after it is ignored
      src_bytes.delete();
      append_byte(8'h00);
      append_byte(8'h80);
      send_source(CLOSE_LAST);
      // comment ended by LF, End on line two
      set_text("//x\n");
      send_source(CLOSE_END);
      // empty source
      src_bytes.delete();
      send_source(CLOSE_END);
   endtask

   task automatic test_random_sources(input int unsigned target);
      int unsigned first_count;
      close_type   ending;
      first_count = live_items;
      while (live_items - first_count < target) begin
         make_source();
         case ($urandom_range(3))
            2:       ending = CLOSE_END;
            3:       ending = CLOSE_ALT;
            default: ending = CLOSE_LAST;
         endcase
         send_source(ending);
      end
   endtask

   // receiver holds off while one-token bytes keep coming
   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int i = 0; i < 20; i++) send_item(CMD_BYTE, punct_chars[i % 9]);
      send_item(CMD_LAST, "}");
      wait_drain();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      fail_count   = 0;
      live_items   = 0;
      hold_request = 1'b0;
      hold_left    = 0;
      tx_idle_pct  = 17;
      rx_idle_pct  = 71;
      clear_scanner();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_ready <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_sources(28);
      wait_drain();

      tx_idle_pct = 71;
      rx_idle_pct = 17;
      test_backpressure();
      test_random_sources(28);
      wait_drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random_sources(28);
      wait_drain();
      repeat (20) @(posedge clock);

      if (fail_count == 0 && awaited_tokens.size() == 0)
         $display("source_byte_tokenizer test passed");
      else
         $display("source_byte_tokenizer test failed");
      $finish;
   end

endmodule
